// ----- rtl/hodd_pkg.sv -----
package hodd_pkg;

  // Coordinate width of every cell position field.
  localparam int COORD_BITS = 10;

  // Result widths.
  localparam int DIST_BITS = 11;
  localparam int REL_BITS  = 4;

  // Segment columns carry a sign and two bits of headroom above the column range.
  localparam int SEG_BITS  = COORD_BITS + 3;

  // Raw distance width before saturation.
  localparam int RAW_BITS  = (COORD_BITS + 1 > DIST_BITS) ? COORD_BITS + 1 : DIST_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [DIST_BITS-1:0]       dist_t;
  typedef logic [REL_BITS-1:0]        rel_t;
  typedef logic signed [SEG_BITS-1:0] seg_t;

  // Relation codes.
  localparam rel_t REL_SAME      = 4'd0;
  localparam rel_t REL_LEFT      = 4'd1;
  localparam rel_t REL_RIGHT     = 4'd2;
  localparam rel_t REL_UP_BASE   = 4'd3;
  localparam rel_t REL_DOWN_BASE = 4'd8;
  localparam rel_t REL_MAX       = 4'd12;

  // Sector offsets from a base code.
  localparam rel_t SECT_OUTER_L = 4'd0;
  localparam rel_t SECT_EDGE_L  = 4'd1;
  localparam rel_t SECT_MID     = 4'd2;
  localparam rel_t SECT_EDGE_R  = 4'd3;
  localparam rel_t SECT_OUTER_R = 4'd4;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } query_t;

endpackage

// ----- rtl/hodd_query_if.sv -----
interface hodd_query_if import hodd_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t first_x;
  coord_t first_y;
  coord_t second_x;
  coord_t second_y;

  modport source (output valid, output first_x, output first_y,
                  output second_x, output second_y, input ready);
  modport sink   (input valid, input first_x, input first_y,
                  input second_x, input second_y, output ready);
endinterface

// ----- rtl/hodd_result_if.sv -----
interface hodd_result_if import hodd_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t hex_distance;
  rel_t  relation;

  modport source (output valid, output hex_distance, output relation, input ready);
  modport sink   (input valid, input hex_distance, input relation, output ready);
endinterface

// ----- rtl/hodd_relation.sv -----
module hodd_relation import hodd_pkg::*; (
  input  query_t q,
  output rel_t   relation
);

  logic [COORD_BITS:0] f_lo, f_hi, s_lo, s_hi;
  seg_t                lo_diff, hi_diff, left_seg, right_seg, fx_s, sx_s;
  rel_t                base, sector;

  always_comb begin
    // Exact half-row terms: (y+1)>>1 and (y+2)>>1.
    f_lo = ({1'b0, q.first_y}  + (COORD_BITS+1)'(1)) >> 1;
    f_hi = ({1'b0, q.first_y}  + (COORD_BITS+1)'(2)) >> 1;
    s_lo = ({1'b0, q.second_y} + (COORD_BITS+1)'(1)) >> 1;
    s_hi = ({1'b0, q.second_y} + (COORD_BITS+1)'(2)) >> 1;

    fx_s = seg_t'({3'b000, q.first_x});
    sx_s = seg_t'({3'b000, q.second_x});

    if (q.first_y >= q.second_y) begin
      lo_diff   = seg_t'({2'b00, s_lo}) - seg_t'({2'b00, f_lo});
      hi_diff   = seg_t'({2'b00, f_hi}) - seg_t'({2'b00, s_hi});
      left_seg  = sx_s + lo_diff;
      right_seg = sx_s + hi_diff;
    end else begin
      lo_diff   = seg_t'({2'b00, s_lo}) - seg_t'({2'b00, f_lo});
      hi_diff   = seg_t'({2'b00, f_hi}) - seg_t'({2'b00, s_hi});
      right_seg = sx_s + lo_diff;
      left_seg  = sx_s + hi_diff;
    end

    if (left_seg > fx_s) begin
      sector = SECT_OUTER_L;
    end else if (left_seg == fx_s) begin
      sector = SECT_EDGE_L;
    end else if (right_seg > fx_s) begin
      sector = SECT_MID;
    end else if (right_seg == fx_s) begin
      sector = SECT_EDGE_R;
    end else begin
      sector = SECT_OUTER_R;
    end

    base = (q.first_y < q.second_y) ? REL_UP_BASE : REL_DOWN_BASE;

    if (q.first_y == q.second_y) begin
      if (q.first_x < q.second_x) begin
        relation = REL_LEFT;
      end else if (q.first_x > q.second_x) begin
        relation = REL_RIGHT;
      end else begin
        relation = REL_SAME;
      end
    end else begin
      relation = base + sector;
    end
  end

endmodule

// ----- rtl/hodd_distance.sv -----
module hodd_distance import hodd_pkg::*; (
  input  query_t q,
  output dist_t  hex_distance
);

  coord_t                dy, adx, dx, half_dy;
  logic                  shift_col;
  logic [RAW_BITS-1:0]   raw;

  always_comb begin
    dy  = (q.first_y >= q.second_y) ? q.first_y - q.second_y : q.second_y - q.first_y;
    adx = (q.first_x >= q.second_x) ? q.first_x - q.second_x : q.second_x - q.first_x;

    // Odd row distance pulls the reference column one step toward the first cell.
    shift_col = dy[0] && ((!q.first_y[0] && (q.second_x < q.first_x)) ||
                          ( q.first_y[0] && (q.second_x > q.first_x)));
    dx      = shift_col ? adx - COORD_BITS'(1) : adx;
    half_dy = dy >> 1;

    if (dx < half_dy) begin
      raw = RAW_BITS'(dy);
    end else begin
      raw = RAW_BITS'(dy) + RAW_BITS'(dx) - RAW_BITS'(half_dy);
    end

    // Saturate only matters when the coordinates are wider than the result.
    if (raw > RAW_BITS'(DIST_MAX)) begin
      hex_distance = DIST_MAX;
    end else begin
      hex_distance = raw[DIST_BITS-1:0];
    end
  end

endmodule

// ----- rtl/hex_offset_distance_direction_unit.sv -----
// Path: an accepted query request passes the input register, then the result
// register, before it appears as its result request.
// Throughput: one request per cycle; the two register stages advance whenever
// the result stage is empty or being taken, so a stall backs up one stage at a time.
// Reset: synchronous, active-high rst empties both stages; no payload is cleared.
module hex_offset_distance_direction_unit import hodd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  hodd_query_if.sink          query,
  hodd_result_if.source       result
);

  // Stage 1: captured query.
  logic   s1_valid;
  query_t s1_q;

  // Stage 2: finished result.
  logic   s2_valid;
  dist_t  s2_dist;
  rel_t   s2_rel;

  logic   s2_advance;
  logic   s1_advance;

  dist_t  calc_dist;
  rel_t   calc_rel;

  // Stage 2 may load when it is empty or its request is being taken downstream.
  assign s2_advance  = !s2_valid || result.ready;
  // Stage 1 may load when it is empty or its content moves on to stage 2.
  assign s1_advance  = !s1_valid || s2_advance;
  assign query.ready = s1_advance;

  // Geometry on the registered query: both paths are short, parallel logic.
  hodd_relation u_relation (
    .q        (s1_q),
    .relation (calc_rel)
  );

  hodd_distance u_distance (
    .q            (s1_q),
    .hex_distance (calc_dist)
  );

  // Control state: valid bits of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        s1_valid <= query.valid;
      end
      if (s2_advance) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Payload: load on advance, hold while stalled.
  always_ff @(posedge clk) begin
    if (s1_advance && query.valid) begin
      s1_q.first_x  <= query.first_x;
      s1_q.first_y  <= query.first_y;
      s1_q.second_x <= query.second_x;
      s1_q.second_y <= query.second_y;
    end
    if (s2_advance && s1_valid) begin
      s2_dist <= calc_dist;
      s2_rel  <= calc_rel;
    end
  end

  assign result.valid        = s2_valid;
  assign result.hex_distance = s2_dist;
  assign result.relation     = s2_rel;

  // Relation code stays within the thirteen defined codes.
  a_rel_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.relation <= REL_MAX))
    else $error("relation code out of range");

  // Same cell and zero distance go together.
  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.relation == REL_SAME) == (result.hex_distance == '0)))
    else $error("same-cell relation and zero distance disagree");

  // Both stages full and the output stalled: no new request can enter.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !result.ready) |-> !query.ready)
    else $error("query accepted while pipeline is full and stalled");

  // A stalled stage-1 entry moves into stage 2 only when stage 2 frees up.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && !result.ready) |=> s1_valid)
    else $error("stage-1 entry lost during stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");

endmodule

// ----- tb/hex_offset_distance_direction_unit_tb.sv -----
`timescale 1ns / 1ps

module hex_offset_distance_direction_unit_tb;
  import hodd_pkg::*;

  // Stimulus plan: a short directed table first, then random requests.
  localparam int DIRECTED_COUNT   = 21;
  localparam int RANDOM_COUNT     = 1080;
  localparam int TOTAL_QUERIES    = DIRECTED_COUNT + RANDOM_COUNT;
  // Drop all idling on both sides for the last stretch of the run.
  localparam int TAIL_START       = TOTAL_QUERIES - 150;
  // Hold the result side off this long once, so the block backs up into its input.
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 60;
  // Hold the query side until every outstanding answer has come back.
  localparam int PAUSE_AT         = 700;
  // Two register stages; the extra wait after draining catches any stray result request.
  localparam int DRAIN_CYCLES     = 20;
  localparam int TIMEOUT_NS       = 500_000;

  // One directed row: the query, plus a typed-in answer where it is obvious.
  typedef struct packed {
    coord_t fx;
    coord_t fy;
    coord_t sx;
    coord_t sy;
    logic   typed;
    dist_t  hex_dist;
    rel_t   rel;
  } hex_row_t;

  // What the block should return for one accepted query.
  typedef struct packed {
    query_t q;
    dist_t  hex_dist;
    rel_t   rel;
  } hex_answer_t;

  logic clk;
  logic rst;

  hodd_query_if  qry ();
  hodd_result_if res ();

  hex_offset_distance_direction_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (qry),
    .result (res)
  );

  hex_answer_t answers_due [$];
  int          pending_answers = 0;
  int          queries_sent    = 0;
  int          mismatches      = 0;
  logic        long_hold_done  = 1'b0;

  // Directed rows. Second cell (10,10) with first rows 8 and 12 walks all five
  // upper and all five lower sectors. The parity rows hit both column shifts of
  // the distance for an odd row gap, and the 511/512 rows cross adjacent rows.
  hex_row_t directed_rows [DIRECTED_COUNT] = '{
    '{10'd0,    10'd0,    10'd0,    10'd0,    1'b1, 11'd0,    REL_SAME},
    '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 11'd0,    REL_SAME},
    '{10'd0,    10'd0,    10'd1023, 10'd0,    1'b1, 11'd1023, REL_LEFT},
    '{10'd1023, 10'd0,    10'd0,    10'd0,    1'b1, 11'd1023, REL_RIGHT},
    '{10'd0,    10'd0,    10'd1023, 10'd1023, 1'b1, 11'd1535, REL_UP_BASE + SECT_OUTER_L},
    '{10'd1023, 10'd1023, 10'd0,    10'd0,    1'b0, 11'd0,    REL_SAME},
    '{10'd0,    10'd1023, 10'd1023, 10'd0,    1'b0, 11'd0,    REL_SAME},
    '{10'd5,    10'd8,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd9,    10'd8,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd10,   10'd8,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd11,   10'd8,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd15,   10'd8,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd5,    10'd12,   10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd9,    10'd12,   10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd10,   10'd12,   10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd11,   10'd12,   10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd15,   10'd12,   10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd9,    10'd9,    10'd10,   10'd10,   1'b0, 11'd0,    REL_SAME},
    '{10'd20,   10'd4,    10'd10,   10'd7,    1'b0, 11'd0,    REL_SAME},
    '{10'd10,   10'd5,    10'd20,   10'd8,    1'b0, 11'd0,    REL_SAME},
    '{10'd512,  10'd511,  10'd512,  10'd512,  1'b0, 11'd0,    REL_SAME}
  };

  // Hex step count and relation code of the first cell seen from the second.
  function automatic hex_answer_t hex_answer(input query_t q);
    int          fx, fy, sx, sy;
    int          f_lo, f_hi, s_lo, s_hi;
    int          left_col, right_col;
    int          dy, cx, dx, steps;
    rel_t        sector;
    hex_answer_t a;
    fx   = q.first_x;
    fy   = q.first_y;
    sx   = q.second_x;
    sy   = q.second_y;
    // Half-row terms of the offset layout: ceil(y/2) and ceil((y+1)/2).
    f_lo = (fy + 1) >> 1;
    f_hi = (fy + 2) >> 1;
    s_lo = (sy + 1) >> 1;
    s_hi = (sy + 2) >> 1;
    if (fy >= sy) begin
      left_col  = sx + (s_lo - f_lo);
      right_col = sx + (f_hi - s_hi);
    end else begin
      right_col = sx + (s_lo - f_lo);
      left_col  = sx + (f_hi - s_hi);
    end
    a.q = q;
    if (fy == sy) begin
      if (fx < sx) a.rel = REL_LEFT;
      else if (fx > sx) a.rel = REL_RIGHT;
      else a.rel = REL_SAME;
    end else begin
      if (left_col > fx) sector = SECT_OUTER_L;
      else if (left_col == fx) sector = SECT_EDGE_L;
      else if (right_col > fx) sector = SECT_MID;
      else if (right_col == fx) sector = SECT_EDGE_R;
      else sector = SECT_OUTER_R;
      a.rel = ((fy < sy) ? REL_UP_BASE : REL_DOWN_BASE) + sector;
    end
    // Distance: mirror the second column across the first on an odd row gap,
    // depending on the parity of the first row.
    dy = (fy > sy) ? fy - sy : sy - fy;
    cx = sx;
    if ((fy % 2 == 0) && (sx < fx) && (dy % 2 == 1)) cx = fx + (fx - sx) - 1;
    else if ((fy % 2 == 1) && (sx > fx) && (dy % 2 == 1)) cx = fx - (sx - fx) + 1;
    dx = (fx > cx) ? fx - cx : cx - fx;
    if (dx < (dy >> 1)) steps = dy;
    else steps = dy + dx - (dy >> 1);
    if (steps > int'(DIST_MAX)) steps = int'(DIST_MAX);
    a.hex_dist = dist_t'(steps);
    return a;
  endfunction

  // Mostly neighborhoods (where sector edges and parity shifts live), plus
  // same-row pairs, border coordinates and fully random pairs.
  function automatic query_t random_query();
    query_t q;
    int     kind;
    kind       = $urandom_range(0, 9);
    q.first_x  = coord_t'($urandom);
    q.first_y  = coord_t'($urandom);
    q.second_x = coord_t'($urandom);
    q.second_y = coord_t'($urandom);
    if (kind <= 4) begin
      q.second_x = q.first_x + coord_t'($urandom_range(0, 12)) - coord_t'(6);
      q.second_y = q.first_y + coord_t'($urandom_range(0, 8)) - coord_t'(4);
    end else if (kind == 5) begin
      q.second_y = q.first_y;
    end else if (kind == 6) begin
      q.first_x  = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 2)) : ~coord_t'($urandom_range(0, 2));
      q.first_y  = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 2)) : ~coord_t'($urandom_range(0, 2));
      q.second_x = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 2)) : ~coord_t'($urandom_range(0, 2));
      q.second_y = $urandom_range(0, 1) ? coord_t'($urandom_range(0, 2)) : ~coord_t'($urandom_range(0, 2));
    end
    return q;
  endfunction

  // Offer one query request and hold it until the block takes it; then record
  // the answer it owes and maybe idle for a burst before the next request.
  task automatic offer_query(input query_t q, input hex_answer_t owed);
    int burst;
    int gap_pct;
    @(negedge clk);
    qry.valid    <= 1'b1;
    qry.first_x  <= q.first_x;
    qry.first_y  <= q.first_y;
    qry.second_x <= q.second_x;
    qry.second_y <= q.second_y;
    do @(posedge clk); while (!qry.ready);
    answers_due.push_back(owed);
    pending_answers++;
    queries_sent++;
    // Alternate stretches with no gaps, light gaps and heavy gaps.
    case ((queries_sent / 128) % 3)
      0:       gap_pct = 0;
      1:       gap_pct = 15;
      default: gap_pct = 40;
    endcase
    if (queries_sent < TAIL_START && $urandom_range(0, 99) < gap_pct) begin
      burst = $urandom_range(1, 6);
      @(negedge clk);
      qry.valid <= 1'b0;
      repeat (burst - 1) @(negedge clk);
    end
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hold reset once, at the start.
  initial begin : reset_gen
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, then always ready.
  initial begin : result_taker
    int burst;
    int stall_pct;
    res.ready = 1'b0;
    wait (!rst);
    forever begin
      case ((queries_sent / 96) % 3)
        0:       stall_pct = 30;
        1:       stall_pct = 0;
        default: stall_pct = 10;
      endcase
      if (!long_hold_done && queries_sent >= LONG_HOLD_AT) begin
        // Hold off long enough for both stages to fill and stall the input.
        res.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (queries_sent < TAIL_START && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 6);
        res.ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end else begin
        res.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Match each taken result request with the oldest answer still owed.
  always @(posedge clk) begin : result_check
    hex_answer_t owed;
    if (!rst && res.valid && res.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with no query pending, got dist %0d rel %0d",
                 $time, res.hex_distance, res.relation);
        mismatches++;
      end else begin
        owed = answers_due.pop_front();
        pending_answers--;
        if (res.hex_distance !== owed.hex_dist) begin
          $display("%0t: hex_distance for (%0d,%0d)-(%0d,%0d): expected %0d, got %0d",
                   $time, owed.q.first_x, owed.q.first_y, owed.q.second_x,
                   owed.q.second_y, owed.hex_dist, res.hex_distance);
          mismatches++;
        end
        if (res.relation !== owed.rel) begin
          $display("%0t: relation for (%0d,%0d)-(%0d,%0d): expected %0d, got %0d",
                   $time, owed.q.first_x, owed.q.first_y, owed.q.second_x,
                   owed.q.second_y, owed.rel, res.relation);
          mismatches++;
        end
      end
    end
  end

  // Query side: walk the directed table, then the random part, then drain.
  initial begin : query_sender
    query_t      q;
    hex_answer_t owed;
    qry.valid    = 1'b0;
    qry.first_x  = '0;
    qry.first_y  = '0;
    qry.second_x = '0;
    qry.second_y = '0;
    wait (!rst);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      q.first_x  = directed_rows[i].fx;
      q.first_y  = directed_rows[i].fy;
      q.second_x = directed_rows[i].sx;
      q.second_y = directed_rows[i].sy;
      owed = hex_answer(q);
      // Use the typed-in answer where the row carries one.
      if (directed_rows[i].typed) begin
        owed.hex_dist = directed_rows[i].hex_dist;
        owed.rel      = directed_rows[i].rel;
      end
      offer_query(q, owed);
    end

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (queries_sent == PAUSE_AT) begin
        // Stop offering and let the block empty completely.
        @(negedge clk);
        qry.valid <= 1'b0;
        wait (pending_answers == 0);
      end
      q = random_query();
      offer_query(q, hex_answer(q));
    end

    @(negedge clk);
    qry.valid <= 1'b0;
    wait (pending_answers == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hodd_pkg.sv
rtl/hodd_query_if.sv
rtl/hodd_result_if.sv
rtl/hodd_relation.sv
rtl/hodd_distance.sv
rtl/hex_offset_distance_direction_unit.sv
tb/hex_offset_distance_direction_unit_tb.sv
